@@ rtl/catmull_rom_path_follower_macros.svh @@
// ----------------------------------------------------------------------------
// catmull rom path follower assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_PATH_FOLLOWER_MACROS_SVH
`define CATMULL_ROM_PATH_FOLLOWER_MACROS_SVH
`ifndef SYNTH
`define CRPF_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("crpf assertion failed");
`define CRPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crpf assertion failed");
`else
`define CRPF_ASSERT(lbl, clk, rstn, expr)
`define CRPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/crpf_pkg.sv @@
// ----------------------------------------------------------------------------
// crpf_pkg
// shared types and codes of the catmull rom path follower
// ----------------------------------------------------------------------------
package crpf_pkg;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [1:0] KIND_ZERO  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_CURVE = 2'd2;

    localparam logic [1:0] REG_NUM_POINTS  = 2'd0;
    localparam logic [1:0] REG_SPEED       = 2'd1;
    localparam logic [1:0] REG_TARGET_LEAD = 2'd2;

    // wide enough for the largest table size
    localparam int IDX_W = 8;
    localparam int T_W   = 18;
    localparam int PT_W  = 96;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        delta_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] aim_x;
        logic signed [31:0] aim_y;
        logic signed [31:0] aim_z;
        logic [3:0]         segment;
        logic               stopped;
    } out_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] seg;
        logic [T_W-1:0]   t;
        logic [T_W-1:0]   aim;
        logic             halted;
    } job_t;

endpackage

@@ rtl/crpf_ram.sv @@
// ----------------------------------------------------------------------------
// crpf_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------------------
module crpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/crpf_queue.sv @@
// ----------------------------------------------------------------------------
// crpf_queue
// two entry job queue between the front and the back
// ----------------------------------------------------------------------------
`include "catmull_rom_path_follower_macros.svh"
module crpf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crpf_pkg::job_t push_job,
    input  logic          pop,
    output crpf_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);
    import crpf_pkg::*;

    job_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    assign head_job = slot_reg[rptr_reg];
    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);

    `CRPF_ASSERT(a_no_overflow, clk, rst_n, !(push && full && !pop))
    `CRPF_ASSERT(a_no_underflow, clk, rst_n, !(pop && empty))
endmodule

@@ rtl/crpf_front.sv @@
// ----------------------------------------------------------------------------
// crpf_front
// accepts items, stores points, advances the path and classifies each tick
// ----------------------------------------------------------------------------
`include "catmull_rom_path_follower_macros.svh"
module crpf_front #(
    parameter int MAX_POINTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  crpf_pkg::in_item_t            in_data,
    input  logic [4:0]                    num_points,
    input  logic [23:0]                   speed,
    input  logic [15:0]                   target_lead,
    input  logic                          q_full,
    input  logic                          q_empty,
    input  logic                          back_busy,
    output logic                          push,
    output crpf_pkg::job_t                push_job,
    output logic                          ram_we,
    output logic [$clog2(MAX_POINTS)-1:0] ram_waddr,
    output logic [crpf_pkg::PT_W-1:0]     ram_wdata
);
    import crpf_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TICK = 1'b1;

    logic           state_reg, state_next;
    logic [AW-1:0]  seg_reg, seg_next;
    logic [T_W-1:0] t_reg, t_next;
    logic           halted_reg, halted_next;
    logic [23:0]    inc_reg;

    logic           accept;
    logic [NW-1:0]  n_act;
    logic [24:0]    t_sum;
    logic [T_W-1:0] t_sat;
    logic [T_W:0]   aim_sum;
    logic [T_W-1:0] aim_sat;
    logic [39:0]    prod;

    assign n_act = (32'(num_points) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points);

    always_comb
    begin
        in_ready = 1'b0;
        if (state_reg == S_IDLE)
        begin
            case (in_data.op)
                OP_WRITE: in_ready = q_empty && !back_busy;
                OP_TICK:  in_ready = !q_full;
                default:  in_ready = 1'b1;
            endcase
        end
    end

    assign accept    = in_valid && in_ready;
    assign ram_we    = accept && (in_data.op == OP_WRITE) &&
                       (32'(in_data.point_index) < MAX_POINTS);
    assign ram_waddr = AW'(in_data.point_index);
    assign ram_wdata = {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    assign prod      = 40'(speed) * 40'(in_data.delta_time);

    always_comb
    begin
        state_next  = state_reg;
        seg_next    = seg_reg;
        t_next      = t_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        t_sum       = 25'(t_reg) + 25'(inc_reg);
        t_sat       = (t_sum > 25'(T_MAX)) ? T_MAX : t_sum[T_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.op == OP_RESTART)
                begin
                    seg_next    = AW'(1);
                    t_next      = '0;
                    halted_next = 1'b0;
                end
                else if (accept && in_data.op == OP_TICK)
                begin
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                push       = 1'b1;
                state_next = S_IDLE;
                if (!halted_reg)
                begin
                    t_next = t_sat;
                    if (t_sat[T_W-1:16] != '0)
                    begin
                        if ((32'(seg_reg) + 3) < 32'(n_act))
                        begin
                            seg_next = seg_reg + AW'(1);
                            t_next   = t_sat - T_W'(65536);
                        end
                        else
                        begin
                            halted_next = 1'b1;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // classify the segment against the table size
    always_comb
    begin
        aim_sum         = (T_W+1)'(t_next) + (T_W+1)'(target_lead);
        aim_sat         = (aim_sum > (T_W+1)'(T_MAX)) ? T_MAX : aim_sum[T_W-1:0];
        push_job.seg    = IDX_W'(seg_next);
        push_job.t      = t_next;
        push_job.aim    = aim_sat;
        push_job.halted = halted_next;
        push_job.kind   = KIND_POINT;
        push_job.addr   = '0;
        if (n_act == '0)
        begin
            push_job.kind = KIND_ZERO;
        end
        else if (32'(seg_next) >= 32'(n_act))
        begin
            push_job.addr = IDX_W'(n_act - NW'(1));
        end
        else if (seg_next == '0)
        begin
            push_job.addr = '0;
        end
        else if ((32'(seg_next) + 2) >= 32'(n_act))
        begin
            push_job.addr = IDX_W'(seg_next);
        end
        else
        begin
            push_job.kind = KIND_CURVE;
            push_job.addr = IDX_W'(seg_next - AW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            seg_reg    <= AW'(1);
            t_reg      <= '0;
            halted_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            seg_reg    <= seg_next;
            t_reg      <= t_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inc_reg <= prod[39:16];
        end
    end

    `CRPF_ASSERT(a_write_when_drained, clk, rst_n,
        !(accept && in_data.op == OP_WRITE) || (q_empty && !back_busy))
endmodule

@@ rtl/crpf_back.sv @@
// ----------------------------------------------------------------------------
// crpf_back
// fetches control points and evaluates the curve on one shared multiplier
// ----------------------------------------------------------------------------
`include "catmull_rom_path_follower_macros.svh"
module crpf_back #(
    parameter int MAX_POINTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  crpf_pkg::job_t                head_job,
    output logic                          pop,
    output logic                          busy,
    output logic [$clog2(MAX_POINTS)-1:0] ram_raddr,
    input  logic [crpf_pkg::PT_W-1:0]     ram_rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output crpf_pkg::out_item_t           out_data
);
    import crpf_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int ACC_W = 44;
    localparam int PR_W  = ACC_W + T_W + 1;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_READ = 3'd1;
    localparam logic [2:0] B_COEF = 3'd2;
    localparam logic [2:0] B_MUL  = 3'd3;
    localparam logic [2:0] B_SAT  = 3'd4;
    localparam logic [2:0] B_DONE = 3'd5;

    logic [2:0]              state_reg, state_next;
    job_t                    job_reg;
    logic [2:0]              rd_cnt_reg, rd_cnt_next;
    logic [1:0]              axis_reg, axis_next;
    logic                    tsel_reg, tsel_next;
    logic [1:0]              step_reg, step_next;
    logic [PT_W-1:0]         p_reg [4];
    logic signed [ACC_W-1:0] c_reg [4];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      res_reg [6];
    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic                    can_load;
    logic [2:0]              n_reads;
    logic signed [31:0]      q [4];
    logic signed [ACC_W-1:0] mul_a, addend, acc_half;
    logic [T_W-1:0]          tt;
    logic signed [PR_W-1:0]  prod;
    logic signed [31:0]      sat_val;
    logic [2:0]              res_idx;
    out_item_t               out_build;

    assign can_load  = !out_valid_reg || out_ready;
    assign n_reads   = (job_reg.kind == KIND_CURVE) ? 3'd4 : 3'd1;
    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign busy      = (state_reg != B_IDLE);
    assign ram_raddr = AW'(job_reg.addr + IDX_W'(rd_cnt_reg));

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            case (axis_reg)
                2'd0:    q[k] = p_reg[k][95:64];
                2'd1:    q[k] = p_reg[k][63:32];
                default: q[k] = p_reg[k][31:0];
            endcase
        end
    end

    // horner step: acc = floor(a * t / 2^16) + c
    always_comb
    begin
        tt     = tsel_reg ? job_reg.aim : job_reg.t;
        mul_a  = (step_reg == 2'd0) ? c_reg[3] : acc_reg;
        case (step_reg)
            2'd0:    addend = c_reg[2];
            2'd1:    addend = c_reg[1];
            default: addend = c_reg[0];
        endcase
        prod     = mul_a * $signed({1'b0, tt});
        acc_half = acc_reg >>> 1;
        if (acc_half > ACC_W'(64'sd2147483647))
        begin
            sat_val = 32'sh7fffffff;
        end
        else if (acc_half < ACC_W'(-64'sd2147483648))
        begin
            sat_val = 32'sh80000000;
        end
        else
        begin
            sat_val = 32'(acc_half);
        end
        res_idx = tsel_reg ? (3'(axis_reg) + 3'd3) : 3'(axis_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        axis_next   = axis_reg;
        tsel_next   = tsel_reg;
        step_next   = step_reg;
        case (state_reg)
            B_IDLE:
            begin
                rd_cnt_next = '0;
                axis_next   = '0;
                tsel_next   = 1'b0;
                step_next   = '0;
                if (!q_empty)
                begin
                    state_next = (head_job.kind == KIND_ZERO) ? B_DONE : B_READ;
                end
            end
            B_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == n_reads)
                begin
                    state_next = (job_reg.kind == KIND_CURVE) ? B_COEF : B_DONE;
                end
            end
            B_COEF: state_next = B_MUL;
            B_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = B_SAT;
                end
            end
            B_SAT:
            begin
                step_next = '0;
                if (!tsel_reg)
                begin
                    tsel_next  = 1'b1;
                    state_next = B_MUL;
                end
                else
                begin
                    tsel_next = 1'b0;
                    axis_next = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? B_DONE : B_COEF;
                end
            end
            B_DONE:
            begin
                if (can_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        out_build.segment = 4'(job_reg.seg);
        out_build.stopped = job_reg.halted;
        case (job_reg.kind)
            KIND_ZERO:
            begin
                out_build.cam_x = '0;
                out_build.cam_y = '0;
                out_build.cam_z = '0;
                out_build.aim_x = '0;
                out_build.aim_y = '0;
                out_build.aim_z = '0;
            end
            KIND_POINT:
            begin
                out_build.cam_x = p_reg[0][95:64];
                out_build.cam_y = p_reg[0][63:32];
                out_build.cam_z = p_reg[0][31:0];
                out_build.aim_x = p_reg[0][95:64];
                out_build.aim_y = p_reg[0][63:32];
                out_build.aim_z = p_reg[0][31:0];
            end
            default:
            begin
                out_build.cam_x = res_reg[0];
                out_build.cam_y = res_reg[1];
                out_build.cam_z = res_reg[2];
                out_build.aim_x = res_reg[3];
                out_build.aim_y = res_reg[4];
                out_build.aim_z = res_reg[5];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_cnt_reg    <= '0;
            axis_reg      <= '0;
            tsel_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            axis_reg   <= axis_next;
            tsel_reg   <= tsel_next;
            step_reg   <= step_next;
            if (state_reg == B_DONE && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
        if (state_reg == B_READ && rd_cnt_reg != 3'd0)
        begin
            p_reg[2'(rd_cnt_reg - 3'd1)] <= ram_rdata;
        end
        if (state_reg == B_COEF)
        begin
            c_reg[0] <= ACC_W'(q[1]) + ACC_W'(q[1]);
            c_reg[1] <= ACC_W'(q[2]) - ACC_W'(q[0]);
            c_reg[2] <= ACC_W'(q[0]) * 2 - ACC_W'(q[1]) * 5 + ACC_W'(q[2]) * 4 - ACC_W'(q[3]);
            c_reg[3] <= ACC_W'(q[1]) * 3 - ACC_W'(q[0]) - ACC_W'(q[2]) * 3 + ACC_W'(q[3]);
        end
        if (state_reg == B_MUL)
        begin
            acc_reg <= ACC_W'(prod >>> 16) + addend;
        end
        if (state_reg == B_SAT)
        begin
            res_reg[res_idx] <= sat_val;
        end
        if (state_reg == B_DONE && can_load)
        begin
            out_reg <= out_build;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CRPF_ASSERT_NEXT(a_done_loads, clk, rst_n, state_reg == B_DONE && can_load,
        out_valid_reg && state_reg == B_IDLE)
endmodule

@@ rtl/catmull_rom_path_follower.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_path_follower
// uniform catmull rom path follower over a table of q16.16 control points
// ----------------------------------------------------------------------------
// input channel: write point, restart or tick transactions (valid/ready).
// write and restart give no result; each tick gives one result transaction
// with the position at t and at t plus lead, the segment and the stop flag.
// a write waits until all earlier ticks have read the table.
// a tick on an inner segment makes 4 table reads, then 6 evaluations of
// 3 horner steps plus a saturate on one shared multiplier; at a path end
// it makes one table read, and on an empty path none.
// on an inner segment the shared multiplier in the back end sets the pace
// of ticks; two ticks may wait in the job queue.
// when the receiver stalls, the result register holds, the back end waits
// and the front keeps taking ticks and restarts until the queue fills.
// reset: segment 1, t 0, paused; num_points 0, speed 0.5, lead 655.
// the point table has no reset; config is written over the apb port.
// ----------------------------------------------------------------------------
module catmull_rom_path_follower #(
    parameter int MAX_POINTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  crpf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output crpf_pkg::out_item_t out_data
);
    import crpf_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    logic [4:0]  num_points_reg;
    logic [23:0] speed_reg;
    logic [15:0] target_lead_reg;
    logic        cfg_wr;

    logic        q_push, q_pop, q_full, q_empty, back_busy;
    job_t        push_job, head_job;
    logic        ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [PT_W-1:0] ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg  <= 5'd0;
            speed_reg       <= 24'd32768;
            target_lead_reg <= 16'd655;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_NUM_POINTS:  num_points_reg  <= pwdata[4:0];
                REG_SPEED:       speed_reg       <= pwdata[23:0];
                REG_TARGET_LEAD: target_lead_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NUM_POINTS:  prdata = 32'(num_points_reg);
            REG_SPEED:       prdata = 32'(speed_reg);
            REG_TARGET_LEAD: prdata = 32'(target_lead_reg);
            default:         prdata = '0;
        endcase
    end

    crpf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .num_points  (num_points_reg),
        .speed       (speed_reg),
        .target_lead (target_lead_reg),
        .q_full      (q_full),
        .q_empty     (q_empty),
        .back_busy   (back_busy),
        .push        (q_push),
        .push_job    (push_job),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    crpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    crpf_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crpf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_job  (head_job),
        .pop       (q_pop),
        .busy      (back_busy),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// catmull rom path follower: directed and random write, restart and tick
// transactions with random gaps and stalls, results checked against an
// in-bench fixed-point path predictor
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crpf_pkg::*;

    localparam int NPTS     = 16;
    localparam int T_ONE    = 65536;
    localparam int T_SAT    = 18'h3FFFF;
    localparam int WDOG_MAX = 20000;
    localparam int SETTLE   = 60;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;

    catmull_rom_path_follower u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // path state mirror
    logic signed [31:0] pt_x [NPTS];
    logic signed [31:0] pt_y [NPTS];
    logic signed [31:0] pt_z [NPTS];
    logic [3:0]         seg_idx;
    logic [17:0]        t_cur;
    logic               paused;
    logic [4:0]         cfg_points;
    logic [23:0]        cfg_speed;
    logic [15:0]        cfg_lead;

    in_item_t  pending_items [$];
    out_item_t expected_poses [$];
    int        errors;
    int        idle_cycles;
    int        in_gap;
    int        out_gap;
    bit        in_acc;
    bit        out_acc;

    always #1 clk = ~clk;

    function automatic longint floor_sh(longint x, int s);
        return x >>> s;
    endfunction

    function automatic logic signed [31:0] axis_at(logic signed [31:0] tab [NPTS],
                                                   int idx, logic [17:0] t);
        int     n;
        longint p0, p1, p2, p3, c0, c1, c2, c3, acc, tt, r;
        n = (cfg_points > NPTS) ? NPTS : cfg_points;
        if (n == 0) return 0;
        if (idx >= n) return tab[n-1];
        if (idx == 0) return tab[0];
        if (idx + 2 >= n) return tab[idx];
        p0 = tab[idx-1]; p1 = tab[idx]; p2 = tab[idx+1]; p3 = tab[idx+2];
        c0 = 2*p1;
        c1 = p2 - p0;
        c2 = 2*p0 - 5*p1 + 4*p2 - p3;
        c3 = -p0 + 3*p1 - 3*p2 + p3;
        tt = longint'(t);
        acc = floor_sh(c3*tt, 16) + c2;
        acc = floor_sh(acc*tt, 16) + c1;
        acc = floor_sh(acc*tt, 16) + c0;
        r = floor_sh(acc, 1);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // advance the path for one accepted transaction and, for a tick, queue its pose
    task automatic follow_path(in_item_t it);
        longint    tn;
        int        n;
        logic [17:0] aim_t;
        out_item_t pose;
        n = (cfg_points > NPTS) ? NPTS : cfg_points;
        case (it.op)
            OP_WRITE:
            begin
                pt_x[it.point_index] = it.coord_x;
                pt_y[it.point_index] = it.coord_y;
                pt_z[it.point_index] = it.coord_z;
            end
            OP_RESTART:
            begin
                seg_idx = 4'd1;
                t_cur   = 18'd0;
                paused  = 1'b0;
            end
            OP_TICK:
            begin
                if (!paused)
                begin
                    tn = t_cur + ((longint'(cfg_speed) * it.delta_time) >> 16);
                    if (tn > T_SAT) tn = T_SAT;
                    t_cur = tn[17:0];
                    if (t_cur >= T_ONE)
                    begin
                        if (seg_idx + 3 < n)
                        begin
                            seg_idx = seg_idx + 4'd1;
                            t_cur   = t_cur - 18'(T_ONE);
                        end
                        else
                            paused = 1'b1;
                    end
                end
                tn = t_cur + cfg_lead;
                aim_t = (tn > T_SAT) ? 18'(T_SAT) : tn[17:0];
                pose.cam_x   = axis_at(pt_x, seg_idx, t_cur);
                pose.cam_y   = axis_at(pt_y, seg_idx, t_cur);
                pose.cam_z   = axis_at(pt_z, seg_idx, t_cur);
                pose.aim_x   = axis_at(pt_x, seg_idx, aim_t);
                pose.aim_y   = axis_at(pt_y, seg_idx, aim_t);
                pose.aim_z   = axis_at(pt_z, seg_idx, aim_t);
                pose.segment = seg_idx;
                pose.stopped = paused;
                expected_poses.push_back(pose);
            end
            default: ;
        endcase
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_acc)
                void'(pending_items.pop_front());
            if (in_acc || !in_valid)
            begin
                if (pending_items.size() == 0)
                    in_valid <= 1'b0;
                else if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items[0];
                    in_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                end
            end
            if (out_acc)
            begin
                out_gap   <= $urandom_range(0, 11) * ($urandom_range(0, 2) != 0);
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_acc  <= in_valid && in_ready;
            out_acc <= out_valid && out_ready;
            if (in_valid && in_ready)
                follow_path(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $realtime, out_data);
                    errors++;
                end
                else if (out_data !== expected_poses[0])
                begin
                    $display("%0t: expected %h actual %h", $realtime,
                             expected_poses[0], out_data);
                    errors++;
                    void'(expected_poses.pop_front());
                end
                else
                    void'(expected_poses.pop_front());
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (pending_items.size() == 0 && expected_poses.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("catmull_rom_path_follower: mismatch");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_NUM_POINTS:  cfg_points = val[4:0];
            REG_SPEED:       cfg_speed  = val[23:0];
            REG_TARGET_LEAD: cfg_lead   = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain;
        while (pending_items.size() != 0 || in_valid || expected_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic in_item_t make_item(logic [1:0] op, int slot, int dt);
        in_item_t it;
        it.op          = op;
        it.point_index = 4'(slot);
        it.coord_x     = rand_coord();
        it.coord_y     = rand_coord();
        it.coord_z     = rand_coord();
        it.delta_time  = 16'(dt);
        return it;
    endfunction

    initial
    begin
        int         sent;
        int         r;
        in_item_t   it;
        clk = 0; rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; in_data = '0; out_ready = 0;
        errors = 0; idle_cycles = 0; in_gap = 0; out_gap = 0;
        in_acc = 0; out_acc = 0;
        seg_idx = 1; t_cur = 0; paused = 1;
        cfg_points = 0; cfg_speed = 24'h8000; cfg_lead = 16'd655;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty path, then fill every slot
        pending_items.push_back(make_item(OP_TICK, 0, 16'hFFFF));
        pending_items.push_back(make_item(OP_RESTART, 0, 0));
        pending_items.push_back(make_item(OP_TICK, 0, 16'd1000));
        for (int i = 0; i < NPTS; i++)
            pending_items.push_back(make_item(OP_WRITE, i, 0));
        it = make_item(2'd3, 5, 16'hFFFF);
        pending_items.push_back(it);
        pending_items.push_back(make_item(OP_TICK, 0, 16'h0000));
        drain();

        // settings sweep including extremes
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: begin apb_write(REG_NUM_POINTS, 16); apb_write(REG_SPEED, 24'hFFFFFF);
                         apb_write(REG_TARGET_LEAD, 16'hFFFF); end
                1: begin apb_write(REG_NUM_POINTS, 31); apb_write(REG_SPEED, 0);
                         apb_write(REG_TARGET_LEAD, 0); end
                2: begin apb_write(REG_NUM_POINTS, 4); apb_write(REG_SPEED, 24'h8000); end
                3: apb_write(REG_NUM_POINTS, 3);
                default:
                begin
                    apb_write(REG_NUM_POINTS, $urandom_range(0, 31));
                    apb_write(REG_SPEED, $urandom_range(0, 24'h3FFFF));
                    apb_write(REG_TARGET_LEAD, $urandom);
                end
            endcase
            sent = 0;
            while (sent < 160)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    pending_items.push_back(make_item(OP_RESTART, 0, $urandom));
                else if (r < 3)
                    pending_items.push_back(make_item(OP_WRITE, $urandom_range(0, 15), $urandom));
                else if (r == 3)
                    pending_items.push_back(make_item(2'd3, $urandom, $urandom));
                else
                    pending_items.push_back(make_item(OP_TICK, $urandom,
                        ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 16'h1FFF)));
                sent++;
            end
            drain();
        end

        if (errors == 0 && expected_poses.size() == 0)
            $display("catmull_rom_path_follower: match");
        else
            $display("catmull_rom_path_follower: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/crpf_pkg.sv
rtl/crpf_ram.sv
rtl/crpf_queue.sv
rtl/crpf_front.sv
rtl/crpf_back.sv
rtl/catmull_rom_path_follower.sv
dv/tb_top.sv
